FILE: rtl/core/alfb_pkg.sv
// Shared types, character constants and helpers of the ASCII LRC frame builder.
`timescale 1ns / 1ps
package alfb_pkg;

  localparam logic [7:0] CHR_COLON     = 8'h3a;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_ALPHA_OFS = 8'h37;
  localparam logic [7:0] CHR_CR        = 8'h0d;
  localparam logic [7:0] CHR_LF        = 8'h0a;
  localparam logic [3:0] NIB_TEN       = 4'ha;

  typedef struct packed {
    logic [7:0] data_char;
    logic       end_of_payload;
  } alfb_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       frame_done;
    logic       run_last;
  } alfb_out_t;

  // Everything one input transaction emits, held until fully drained.
  typedef struct packed {
    logic       colon;
    logic [7:0] echo;
    logic       trailer;
    logic [7:0] lrc;
  } alfb_burst_t;

  typedef enum logic [2:0] {
    SLOT_COLON,
    SLOT_ECHO,
    SLOT_HI,
    SLOT_LO,
    SLOT_CR,
    SLOT_LF
  } alfb_slot_t;

  // Offset decode; non-hex characters simply wrap.
  function automatic logic [7:0] char_value(input logic [7:0] c);
    if (c < CHR_COLON) begin
      char_value = c - CHR_ZERO;
    end else begin
      char_value = c - CHR_ALPHA_OFS;
    end
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < NIB_TEN) begin
      nibble_char = {4'h0, n} + CHR_ZERO;
    end else begin
      nibble_char = {4'h0, n} + CHR_ALPHA_OFS;
    end
  endfunction

endpackage

FILE: rtl/core/alfb_accum.sv
// Frame state and LRC accumulation; forms the output burst of one transaction.
`timescale 1ns / 1ps
module alfb_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  alfb_pkg::alfb_in_t   item,
  output alfb_pkg::alfb_burst_t burst
);
  import alfb_pkg::*;

  logic       in_frame, in_frame_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] held_high_nibble, held_high_nibble_next;
  logic       have_high, have_high_next;

  logic [7:0] val;
  logic [7:0] sum_after;

  always_comb begin
    val       = char_value(item.data_char);
    // low character of a pair closes a byte
    sum_after = have_high ? (running_sum + {held_high_nibble, 4'h0} + val) : running_sum;

    burst.colon   = !in_frame;
    burst.echo    = item.data_char;
    burst.trailer = item.end_of_payload;
    burst.lrc     = 8'h00 - sum_after;

    in_frame_next         = in_frame;
    running_sum_next      = running_sum;
    held_high_nibble_next = held_high_nibble;
    have_high_next        = have_high;
    if (load) begin
      if (item.end_of_payload) begin
        in_frame_next         = 1'b0;
        running_sum_next      = 8'h00;
        held_high_nibble_next = 4'h0;
        have_high_next        = 1'b0;
      end else begin
        in_frame_next    = 1'b1;
        running_sum_next = sum_after;
        have_high_next   = !have_high;
        if (!have_high) begin
          held_high_nibble_next = val[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      running_sum      <= 8'h00;
      held_high_nibble <= 4'h0;
      have_high        <= 1'b0;
    end else begin
      in_frame         <= in_frame_next;
      running_sum      <= running_sum_next;
      held_high_nibble <= held_high_nibble_next;
      have_high        <= have_high_next;
    end
  end

endmodule

FILE: rtl/core/alfb_serial.sv
// Burst register and character serializer with output handshake.
`timescale 1ns / 1ps
module alfb_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  alfb_pkg::alfb_burst_t burst_in,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output alfb_pkg::alfb_out_t   out_data
);
  import alfb_pkg::*;

  alfb_burst_t burst;
  logic        valid;
  alfb_slot_t  slot, slot_next;
  logic        last_now;
  logic        take;

  always_comb begin
    last_now = (slot == SLOT_LF) || ((slot == SLOT_ECHO) && !burst.trailer);
    take     = valid && !out_stall;
    ready    = !valid || (take && last_now);

    out_data.frame_done = (slot == SLOT_LF);
    out_data.run_last   = last_now;
    case (slot)
      SLOT_COLON: out_data.out_char = CHR_COLON;
      SLOT_ECHO:  out_data.out_char = burst.echo;
      SLOT_HI:    out_data.out_char = nibble_char(burst.lrc[7:4]);
      SLOT_LO:    out_data.out_char = nibble_char(burst.lrc[3:0]);
      SLOT_CR:    out_data.out_char = CHR_CR;
      SLOT_LF:    out_data.out_char = CHR_LF;
      default:    out_data.out_char = CHR_LF;
    endcase

    slot_next = slot;
    if (load) begin
      slot_next = burst_in.colon ? SLOT_COLON : SLOT_ECHO;
    end else if (take && !last_now) begin
      case (slot)
        SLOT_COLON: slot_next = SLOT_ECHO;
        SLOT_ECHO:  slot_next = SLOT_HI;
        SLOT_HI:    slot_next = SLOT_LO;
        SLOT_LO:    slot_next = SLOT_CR;
        SLOT_CR:    slot_next = SLOT_LF;
        default:    slot_next = SLOT_ECHO;
      endcase
    end
  end

  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= SLOT_ECHO;
      valid <= 1'b0;
    end else begin
      slot <= slot_next;
      if (load) begin
        valid <= 1'b1;
      end else if (take && last_now) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule

FILE: rtl/core/ascii_lrc_frame_builder_top.sv
// Top level of the ASCII LRC frame builder.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  input    | char_valid   | char_stall   | char_item  (data_char, eop)
//  output   | frame_valid  | frame_stall  | frame_item (char, done, last)
//
// Each input transaction is decoded into a burst register, then drained
// one output character per cycle while frame_stall is low: one character
// for a mid-frame input, two when it opens a frame, up to six when it ends one.
// The output serializer sets the rate: a new input is taken in the cycle
// the last character of the previous burst leaves, so plain payload flows
// at one character per cycle while frame_stall is low.
// rst is synchronous; it closes any open frame and empties the burst register.
// char_stall is held high while rst is asserted, so nothing is taken in reset.
// char_stall follows frame_stall combinationally while a burst is on its last character.
`timescale 1ns / 1ps
module ascii_lrc_frame_builder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  alfb_pkg::alfb_in_t  char_item,
  output logic                frame_valid,
  input  logic                frame_stall,
  output alfb_pkg::alfb_out_t frame_item
);
  import alfb_pkg::*;

  alfb_burst_t burst;
  logic        ready;
  logic        load;

  // a transaction is taken when the burst register is empty or frees up this cycle,
  // never while in reset
  assign char_stall = rst || !ready;
  assign load       = char_valid && !char_stall;

  alfb_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .item  (char_item),
    .burst (burst)
  );

  alfb_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst_in  (burst),
    .ready     (ready),
    .out_valid (frame_valid),
    .out_stall (frame_stall),
    .out_data  (frame_item)
  );

endmodule

FILE: rtl/core/alfb_checker.sv
// Port-level assertions for the ASCII LRC frame builder, bound to the top level.
`timescale 1ns / 1ps
module alfb_checker (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_stall,
  input alfb_pkg::alfb_in_t  char_item,
  input logic                frame_valid,
  input logic                frame_stall,
  input alfb_pkg::alfb_out_t frame_item
);
  import alfb_pkg::*;

  // held output transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid && $stable(frame_item))
    else $error("output changed while stalled");

  // an accepted input always produces output next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall |=> frame_valid)
    else $error("accepted input produced no output");

  a_done_is_lf: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_item.frame_done |->
      frame_item.run_last && (frame_item.out_char == CHR_LF))
    else $error("frame_done not on closing LF");

  // input with end of payload is followed by a trailer, never a bare last echo
  a_trailer: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && char_item.end_of_payload |=>
      frame_valid && !frame_item.run_last)
    else $error("missing LRC trailer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("output valid after reset");

endmodule

bind ascii_lrc_frame_builder_top alfb_checker u_alfb_checker (
  .clk         (clk),
  .rst         (rst),
  .char_valid  (char_valid),
  .char_stall  (char_stall),
  .char_item   (char_item),
  .frame_valid (frame_valid),
  .frame_stall (frame_stall),
  .frame_item  (frame_item)
);
